>>> hdl/tbbg_pkg.sv
// Package for the turbo / burst button gate: widths, constants, codes and the
// structs passed between the controller, datapath and register block.
// No dependencies.
package tbbg_pkg;

    localparam int BUTTONS = 16;
    localparam int BTN_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int MASK_W  = 16;
    localparam logic [MASK_W-1:0] BTN_MASK = {MASK_W{1'b1}} >> (MASK_W - BUTTONS);

    localparam int TIME_W  = 32;
    localparam int UNITS_W = 10;
    localparam int WIN_W   = 8;
    localparam int RATE_W  = 8;
    localparam int DUTY_W  = 7;
    localparam int MODES_W = 32;
    localparam int LIM_W   = 11;

    localparam int CYCLE_UNITS = 1000;
    localparam int DUTY_SCALE  = 10;

    // floor(x/1000) = (x * RECIP_T) >> 41, exact for any 32-bit x
    localparam logic [31:0] RECIP_T    = 32'd2199023256;
    localparam int          RECIP_T_SH = 41;
    localparam int          QT_W       = 64 - RECIP_T_SH;
    localparam int          QRATE_W    = QT_W + RATE_W;
    // floor(s/1000) = (s * RECIP_S) >> 28, exact for s < 2^18
    localparam int          SUM_W      = 18;
    localparam logic [18:0] RECIP_S    = 19'd268436;
    localparam int          RECIP_S_SH = 28;
    localparam int          PROD_S_W   = SUM_W + 19;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [RATE_W-1:0] RATE_RST = 8'd10;
    localparam logic [DUTY_W-1:0] DUTY_RST = 7'd50;

    typedef enum logic [1:0] {
        REG_MODES   = 2'd0,
        REG_RATE    = 2'd1,
        REG_DUTY    = 2'd2,
        REG_WINDOWS = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_TURBO = 2'd1,
        MODE_AUTO  = 2'd2,
        MODE_BURST = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_KEEP    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_START   = 2'd2,
        OP_ADVANCE = 2'd3
    } t_gen_op;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ISSUE = 2'd1,
        ST_DRAIN = 2'd2,
        ST_DONE  = 2'd3
    } t_state;

    typedef struct packed {
        logic [MODES_W-1:0] modes;
        logic [RATE_W-1:0]  rate;
        logic [DUTY_W-1:0]  duty;
        logic [WIN_W-1:0]   windows;
    } t_cfg;

    typedef struct packed {
        logic             load;
        logic             issue;
        logic [BTN_W-1:0] idx;
        logic             push;
    } t_ctrl_cmd;

    typedef struct packed {
        logic pipe_empty;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/tbbg_if.sv
// Handshake channel interfaces for the button gate: request in, result out.
// Depends on tbbg_pkg.
interface tbbg_in_if;
    logic                         valid;
    logic                         ready;
    logic [tbbg_pkg::TIME_W-1:0]  time_ms;
    logic [tbbg_pkg::MASK_W-1:0]  pressed_mask;
    logic [tbbg_pkg::MASK_W-1:0]  consumed_mask;

    modport source (output valid, output time_ms, output pressed_mask,
                    output consumed_mask, input ready);
    modport sink   (input valid, input time_ms, input pressed_mask,
                    input consumed_mask, output ready);
endinterface

interface tbbg_out_if;
    logic                        valid;
    logic                        ready;
    logic [tbbg_pkg::MASK_W-1:0] gated_mask;

    modport source (output valid, output gated_mask, input ready);
    modport sink   (input valid, input gated_mask, output ready);
endinterface

>>> hdl/tbbg_regs.sv
// APB-style configuration registers for the button gate.
// Depends on tbbg_pkg.
module tbbg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbbg_pkg::PADDR_W-1:0]   paddr,
    input  logic [tbbg_pkg::PDATA_W-1:0]   pwdata,
    output logic [tbbg_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output tbbg_pkg::t_cfg                 o_cfg
);

    tbbg_pkg::t_cfg     r_cfg;
    tbbg_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = tbbg_pkg::t_reg_idx'(paddr[tbbg_pkg::PADDR_W-1:2]);
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modes   <= '0;
            r_cfg.rate    <= tbbg_pkg::RATE_RST;
            r_cfg.duty    <= tbbg_pkg::DUTY_RST;
            r_cfg.windows <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                tbbg_pkg::REG_MODES:   r_cfg.modes   <= pwdata[tbbg_pkg::MODES_W-1:0];
                tbbg_pkg::REG_RATE:    r_cfg.rate    <= pwdata[tbbg_pkg::RATE_W-1:0];
                tbbg_pkg::REG_DUTY:    r_cfg.duty    <= pwdata[tbbg_pkg::DUTY_W-1:0];
                tbbg_pkg::REG_WINDOWS: r_cfg.windows <= pwdata[tbbg_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tbbg_pkg::REG_MODES:   prdata = tbbg_pkg::PDATA_W'(r_cfg.modes);
            tbbg_pkg::REG_RATE:    prdata = tbbg_pkg::PDATA_W'(r_cfg.rate);
            tbbg_pkg::REG_DUTY:    prdata = tbbg_pkg::PDATA_W'(r_cfg.duty);
            tbbg_pkg::REG_WINDOWS: prdata = tbbg_pkg::PDATA_W'(r_cfg.windows);
            default:               prdata = '0;
        endcase
    end

endmodule

>>> hdl/tbbg_ctrl.sv
// Controller FSM: takes a request, issues one button per cycle into the
// datapath pipeline, waits for it to drain, then hands off the result.
// Depends on tbbg_pkg.
module tbbg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tbbg_pkg::t_dp_stat    i_stat,
    output tbbg_pkg::t_ctrl_cmd   o_cmd
);

    localparam logic [tbbg_pkg::BTN_W-1:0] LAST_IDX =
        tbbg_pkg::BTN_W'(tbbg_pkg::BUTTONS - 1);

    tbbg_pkg::t_state             r_state, n_state;
    logic [tbbg_pkg::BTN_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbbg_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            tbbg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = tbbg_pkg::ST_ISSUE;
                end
            end
            tbbg_pkg::ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.idx   = r_cnt;
                if (r_cnt == LAST_IDX) begin
                    n_state = tbbg_pkg::ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tbbg_pkg::ST_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = tbbg_pkg::ST_DONE;
                end
            end
            tbbg_pkg::ST_DONE: begin
                // output register must be free or emptying this cycle
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = tbbg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tbbg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/tbbg_dp.sv
// Datapath: per-button generator state, six-stage phase pipeline (elapsed
// time, reciprocal divides by 1000), writeback decision and output register.
// Depends on tbbg_pkg.
module tbbg_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tbbg_pkg::t_ctrl_cmd           i_cmd,
    output tbbg_pkg::t_dp_stat            o_stat,
    input  tbbg_pkg::t_cfg                i_cfg,
    input  logic [tbbg_pkg::TIME_W-1:0]   i_time_ms,
    input  logic [tbbg_pkg::MASK_W-1:0]   i_pressed_mask,
    input  logic [tbbg_pkg::MASK_W-1:0]   i_consumed_mask,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tbbg_pkg::MASK_W-1:0]   o_gated_mask
);

    localparam int B     = tbbg_pkg::BUTTONS;
    localparam int BW    = tbbg_pkg::BTN_W;
    localparam int TW    = tbbg_pkg::TIME_W;
    localparam int UW    = tbbg_pkg::UNITS_W;
    localparam int WW    = tbbg_pkg::WIN_W;
    localparam int MW    = tbbg_pkg::MASK_W;
    localparam int QW    = tbbg_pkg::QT_W;
    localparam int QRW   = tbbg_pkg::QRATE_W;
    localparam int SW    = tbbg_pkg::SUM_W;
    localparam int PSW   = tbbg_pkg::PROD_S_W;
    localparam int LW    = tbbg_pkg::LIM_W;
    localparam int DEPTH = 6;

    // generator state
    logic          r_active [B];
    logic          r_on     [B];
    logic [UW-1:0] r_units  [B];
    logic [WW-1:0] r_wl     [B];
    logic [TW-1:0] r_last   [B];
    logic [MW-1:0] r_prev;

    // latched request
    logic [TW-1:0] r_now;
    logic [MW-1:0] r_held, r_rising, r_consumed, r_gated;
    logic [MW-1:0] raw;

    // output register
    logic          r_out_valid;
    logic [MW-1:0] r_out_mask;

    // pipeline
    logic [DEPTH-1:0] r_vld;
    logic [BW-1:0]    r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx, r_s5_idx, r_s6_idx;
    logic [TW-1:0]    r_s1_elapsed, r_s2_elapsed;
    logic [UW-1:0]    r_s1_units, r_s2_units, r_s3_units;
    logic [63:0]      r_s2_prod;
    logic [UW-1:0]    r_s3_rem;
    logic [QRW-1:0]   r_s3_qrate, r_s4_qrate, r_s5_qrate;
    logic [SW-1:0]    r_s4_sum, r_s5_sum;
    logic [PSW-1:0]   r_s5_prod;
    logic [UW-1:0]    r_s6_units;
    logic [31:0]      r_s6_cycles;

    logic [QW-1:0]    s3_q;
    logic [TW-1:0]    s3_qk, s3_rem_full;
    logic [7:0]       s6_q2;
    logic [SW-1:0]    s6_q2k, s6_units_full;

    // writeback
    tbbg_pkg::t_mode   wb_mode;
    tbbg_pkg::t_gen_op wb_op;
    logic              wb_pressed, wb_rise, wb_cons, wb_act;
    logic [WW-1:0]     wb_wl, wb_wl_sub, wb_start_wl;
    logic [LW-1:0]     duty_lim;
    logic              on_adv, cyc_ge, adv_clear;
    logic              n_active, n_on;
    logic [UW-1:0]     n_units;
    logic [WW-1:0]     n_wl;
    logic [TW-1:0]     n_last;
    logic              n_gbit;

    assign raw = i_pressed_mask & tbbg_pkg::BTN_MASK;

    // ---- request latch and previous mask ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_cmd.load) begin
            r_prev <= raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now      <= i_time_ms;
            r_held     <= raw & ~i_consumed_mask;
            r_rising   <= raw & ~r_prev & ~i_consumed_mask;
            r_consumed <= i_consumed_mask;
            r_gated    <= '0;
        end else if (r_vld[DEPTH-1]) begin
            r_gated[r_s6_idx] <= n_gbit;
        end
    end

    // ---- pipeline ----
    assign s3_q        = r_s2_prod[63 -: QW];
    assign s3_qk       = TW'(s3_q) * TW'(tbbg_pkg::CYCLE_UNITS);
    assign s3_rem_full = r_s2_elapsed - s3_qk;
    assign s6_q2       = r_s5_prod[tbbg_pkg::RECIP_S_SH +: 8];
    assign s6_q2k      = SW'(s6_q2) * SW'(tbbg_pkg::CYCLE_UNITS);
    assign s6_units_full = r_s5_sum - s6_q2k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], i_cmd.issue};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: elapsed time since the entry's last update
        r_s1_idx     <= i_cmd.idx;
        r_s1_elapsed <= r_now - r_last[i_cmd.idx];
        r_s1_units   <= r_units[i_cmd.idx];
        // stage 2: reciprocal product for elapsed / 1000
        r_s2_idx     <= r_s1_idx;
        r_s2_elapsed <= r_s1_elapsed;
        r_s2_units   <= r_s1_units;
        r_s2_prod    <= 64'(r_s1_elapsed) * 64'(tbbg_pkg::RECIP_T);
        // stage 3: whole seconds times rate, leftover ms
        r_s3_idx     <= r_s2_idx;
        r_s3_units   <= r_s2_units;
        r_s3_rem     <= s3_rem_full[UW-1:0];
        r_s3_qrate   <= QRW'(s3_q) * QRW'(i_cfg.rate);
        // stage 4: units + leftover ms * rate
        r_s4_idx     <= r_s3_idx;
        r_s4_qrate   <= r_s3_qrate;
        r_s4_sum     <= SW'(r_s3_units) + SW'(r_s3_rem) * SW'(i_cfg.rate);
        // stage 5: reciprocal product for sum / 1000
        r_s5_idx     <= r_s4_idx;
        r_s5_qrate   <= r_s4_qrate;
        r_s5_sum     <= r_s4_sum;
        r_s5_prod    <= PSW'(r_s4_sum) * PSW'(tbbg_pkg::RECIP_S);
        // stage 6: new units and completed cycles
        r_s6_idx     <= r_s5_idx;
        r_s6_units   <= s6_units_full[UW-1:0];
        r_s6_cycles  <= 32'(r_s5_qrate) + 32'(s6_q2);
    end

    // ---- writeback decision ----
    always_comb begin
        wb_mode     = tbbg_pkg::t_mode'(i_cfg.modes[{r_s6_idx, 1'b0} +: 2]);
        wb_pressed  = r_held[r_s6_idx];
        wb_rise     = r_rising[r_s6_idx];
        wb_cons     = r_consumed[r_s6_idx];
        wb_act      = r_active[r_s6_idx];
        wb_wl       = r_wl[r_s6_idx];
        wb_start_wl = '0;

        duty_lim  = LW'(i_cfg.duty) * LW'(tbbg_pkg::DUTY_SCALE);
        on_adv    = LW'(r_s6_units) < duty_lim;
        cyc_ge    = r_s6_cycles >= 32'(wb_wl);
        wb_wl_sub = wb_wl - r_s6_cycles[WW-1:0];
        // burst ends when the cycles run out, or on the last window's off phase
        adv_clear = (wb_wl != '0) && (cyc_ge || (wb_wl_sub == WW'(1) && !on_adv));

        wb_op = tbbg_pkg::OP_KEEP;
        if (wb_cons) begin
            wb_op = tbbg_pkg::OP_CLEAR;
        end else begin
            case (wb_mode)
                tbbg_pkg::MODE_OFF: begin
                    wb_op = tbbg_pkg::OP_CLEAR;
                end
                tbbg_pkg::MODE_TURBO: begin
                    if (!wb_pressed)  wb_op = tbbg_pkg::OP_CLEAR;
                    else if (!wb_act) wb_op = tbbg_pkg::OP_START;
                    else              wb_op = tbbg_pkg::OP_ADVANCE;
                end
                tbbg_pkg::MODE_AUTO: begin
                    if (wb_rise)     wb_op = wb_act ? tbbg_pkg::OP_CLEAR : tbbg_pkg::OP_START;
                    else if (wb_act) wb_op = tbbg_pkg::OP_ADVANCE;
                end
                tbbg_pkg::MODE_BURST: begin
                    wb_start_wl = i_cfg.windows;
                    if (wb_rise)     wb_op = tbbg_pkg::OP_START;
                    else if (wb_act) wb_op = tbbg_pkg::OP_ADVANCE;
                end
                default: ;
            endcase
        end

        if (wb_op == tbbg_pkg::OP_ADVANCE && adv_clear) begin
            wb_op = tbbg_pkg::OP_CLEAR;
        end

        n_active = wb_act;
        n_on     = r_on[r_s6_idx];
        n_units  = r_units[r_s6_idx];
        n_wl     = wb_wl;
        n_last   = r_last[r_s6_idx];
        case (wb_op)
            tbbg_pkg::OP_CLEAR: begin
                n_active = 1'b0;
                n_on     = 1'b0;
                n_units  = '0;
                n_wl     = '0;
                n_last   = '0;
            end
            tbbg_pkg::OP_START: begin
                n_active = 1'b1;
                n_on     = 1'b1;
                n_units  = '0;
                n_wl     = wb_start_wl;
                n_last   = r_now;
            end
            tbbg_pkg::OP_ADVANCE: begin
                n_on    = on_adv;
                n_units = r_s6_units;
                n_last  = r_now;
                if (wb_wl != '0) n_wl = wb_wl_sub;
            end
            default: ;
        endcase

        if (wb_cons)                             n_gbit = 1'b0;
        else if (wb_mode == tbbg_pkg::MODE_OFF)  n_gbit = wb_pressed;
        else                                     n_gbit = n_active && n_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < B; b++) begin
                r_active[b] <= 1'b0;
                r_on[b]     <= 1'b0;
                r_units[b]  <= '0;
                r_wl[b]     <= '0;
                r_last[b]   <= '0;
            end
        end else if (r_vld[DEPTH-1]) begin
            r_active[r_s6_idx] <= n_active;
            r_on[r_s6_idx]     <= n_on;
            r_units[r_s6_idx]  <= n_units;
            r_wl[r_s6_idx]     <= n_wl;
            r_last[r_s6_idx]   <= n_last;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_mask <= r_gated;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_gated_mask      = r_out_mask;
    assign o_stat.pipe_empty = (r_vld == '0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

>>> hdl/turbo_burst_button_gate_top.sv
// Top level of the turbo / auto-burst / burst button gate.
// Depends on tbbg_pkg, tbbg_if, tbbg_regs, tbbg_ctrl, tbbg_dp.
//
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      time_ms[31:0], pressed_mask[15:0], consumed_mask[15:0]
//  o_out     out  valid / ready      gated_mask[15:0]
//  apb       in   psel/penable/pready  paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One request at a time: each of the BUTTONS buttons is issued into a six-stage
// pipeline, which then drains before the result goes to the output register.
// Reset is synchronous, active low; all generators and the previous mask clear.
// A finished result sits in the output register; the next request is taken
// while it waits, and only the hand-off stalls until the register frees up.
module turbo_burst_button_gate_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tbbg_in_if.sink                       i_in,
    tbbg_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbbg_pkg::PADDR_W-1:0]  paddr,
    input  logic [tbbg_pkg::PDATA_W-1:0]  pwdata,
    output logic [tbbg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    tbbg_pkg::t_cfg      cfg;
    tbbg_pkg::t_ctrl_cmd cmd;
    tbbg_pkg::t_dp_stat  stat;
    logic                in_ready;
    logic                out_valid;
    logic [tbbg_pkg::MASK_W-1:0] gated_mask;

    tbbg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tbbg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tbbg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg           (cfg),
        .i_time_ms       (i_in.time_ms),
        .i_pressed_mask  (i_in.pressed_mask),
        .i_consumed_mask (i_in.consumed_mask),
        .o_out_valid     (out_valid),
        .i_out_ready     (o_out.ready),
        .o_gated_mask    (gated_mask)
    );

    assign i_in.ready       = in_ready;
    assign o_out.valid      = out_valid;
    assign o_out.gated_mask = gated_mask;

endmodule

>>> hdl/tbbg_checker.sv
// Port-level checks for the button gate top, bound to it below.
// Depends on tbbg_pkg and turbo_burst_button_gate_top.
module tbbg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [tbbg_pkg::MASK_W-1:0] i_gated_mask
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_gated_mask))
        else $error("result changed while stalled");

    // one request in flight: ready drops right after a request is taken
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while busy");

    // a new result only appears after a busy stretch
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without work");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("bad state after reset");

endmodule

bind turbo_burst_button_gate_top tbbg_checker u_tbbg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_gated_mask (o_out.gated_mask)
);
